/* rtl/page_type_map_allocator_defines.svh */
// ----------------------------------------------------------------------------
// page_type_map_allocator_defines: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_TYPE_MAP_ALLOCATOR_DEFINES_SVH
`define PAGE_TYPE_MAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PTMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptma_pkg.sv */
// ----------------------------------------------------------------------------
// ptma_pkg: page type map allocator package
// Field widths, operation and status codes, controller states, result struct.
// ----------------------------------------------------------------------------
package ptma_pkg;

  localparam int PAGE_W   = 20;
  localparam int COUNT_W  = 13;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int WIDE_W   = 21;
  localparam int SUM_W    = 22;
  localparam int OP_W     = 2;

  localparam logic [TYPE_W-1:0] TYPE_FREE     = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_UNUSABLE = 4'd2;

  localparam logic CFG_LOWEST_PAGE  = 1'b0;
  localparam logic CFG_HIGHEST_PAGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_BOUNDS  = 3'd1,
    STAT_NOSPACE = 3'd2,
    STAT_ZERO    = 3'd3,
    STAT_ABOVE32 = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CHECK,
    S_WRITE,
    S_RDWAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   first_page;
    logic [TYPE_W-1:0]   read_type;
  } res_t;

endpackage

/* rtl/page_type_map_allocator.sv */
// ----------------------------------------------------------------------------
// page_type_map_allocator: first-fit contiguous page allocator
// Per-page 4-bit type table with mark, allocate and read operations.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, operation, start, count, type | to block
//  out     | out_valid/out_ready, status, first_page, read_type | from block
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata              | to block
//
//  Read takes one table read. Mark fills page_count entries; allocate scans
//  entries, then fills page_count entries; scan and fill move one table entry
//  per cycle on the memory port. After reset a clearing pass writes every
//  entry with in_ready low. One item is in work at a time; the output register
//  holds a finished transfer while the next item is taken.
// ----------------------------------------------------------------------------
module page_type_map_allocator #(
  parameter int TABLE_PAGES = 4096,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [ptma_pkg::PAGE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ptma_pkg::OP_W-1:0]      in_operation,
  input  logic [ptma_pkg::PAGE_W-1:0]    in_start_page,
  input  logic [ptma_pkg::COUNT_W-1:0]   in_page_count,
  input  logic [ptma_pkg::TYPE_W-1:0]    in_page_type,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ptma_pkg::STATUS_W-1:0]  out_status,
  output logic [ptma_pkg::PAGE_W-1:0]    out_first_page,
  output logic [ptma_pkg::TYPE_W-1:0]    out_read_type
);
  import ptma_pkg::*;

  localparam int IdxW = $clog2(TABLE_PAGES);

  logic              res_valid, res_ready;
  res_t              res;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [TYPE_W-1:0] mem_wdata, mem_rdata;
  logic              out_valid_r;
  res_t              out_res_r;

  ptma_ctrl #(
    .TABLE_PAGES (TABLE_PAGES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_start_page (in_start_page),
    .in_page_count (in_page_count),
    .in_page_type  (in_page_type),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  ptma_table #(
    .DEPTH (TABLE_PAGES)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_first_page = out_res_r.first_page;
  assign out_read_type  = out_res_r.read_type;

endmodule

/* rtl/ptma_table.sv */
// ----------------------------------------------------------------------------
// ptma_table: page type memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptma_table #(
  parameter int DEPTH = 4096,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AddrW-1:0]            waddr,
  input  logic [ptma_pkg::TYPE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AddrW-1:0]            raddr,
  output logic [ptma_pkg::TYPE_W-1:0] rdata_r
);
  import ptma_pkg::*;

  logic [TYPE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/ptma_ctrl.sv */
// ----------------------------------------------------------------------------
// ptma_ctrl: page type map sequencer
// Config registers, bounds checks, first-fit scan, range fill, clearing pass.
// ----------------------------------------------------------------------------
`include "page_type_map_allocator_defines.svh"

module ptma_ctrl #(
  parameter int TABLE_PAGES = 4096,
  parameter int PAGE_BYTES  = 4096,
  localparam int IdxW  = $clog2(TABLE_PAGES),
  localparam int SpanW = $clog2(TABLE_PAGES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [ptma_pkg::PAGE_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ptma_pkg::OP_W-1:0]    in_operation,
  input  logic [ptma_pkg::PAGE_W-1:0]  in_start_page,
  input  logic [ptma_pkg::COUNT_W-1:0] in_page_count,
  input  logic [ptma_pkg::TYPE_W-1:0]  in_page_type,
  output logic                         res_valid,
  input  logic                         res_ready,
  output ptma_pkg::res_t               res,
  output logic                         mem_we,
  output logic [IdxW-1:0]              mem_waddr,
  output logic [ptma_pkg::TYPE_W-1:0]  mem_wdata,
  output logic                         mem_re,
  output logic [IdxW-1:0]              mem_raddr,
  input  logic [ptma_pkg::TYPE_W-1:0]  mem_rdata
);
  import ptma_pkg::*;

  localparam logic [SUM_W-1:0] ADDR_PAGE_LIMIT = SUM_W'(64'hFFFF_FFFF / PAGE_BYTES);

  state_t               state_r, state_nxt;
  logic [PAGE_W-1:0]    lowest_r, highest_r;
  op_t                  op_r, op_nxt;
  logic [PAGE_W-1:0]    start_r, start_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic [SpanW-1:0]     span_r, span_nxt;
  logic [SpanW-1:0]     issue_idx_r, issue_idx_nxt;
  logic [IdxW-1:0]      eval_idx_r, eval_idx_nxt;
  logic                 rd_pending_r, rd_pending_nxt;
  logic [COUNT_W-1:0]   run_r, run_nxt;
  logic [IdxW-1:0]      found_idx_r, found_idx_nxt;
  logic [IdxW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [COUNT_W-1:0]   wr_left_r, wr_left_nxt;
  logic [TYPE_W-1:0]    wr_type_r, wr_type_nxt;
  logic [IdxW-1:0]      clr_idx_r, clr_idx_nxt;
  res_t                 res_r, res_nxt;

  logic [PAGE_W-1:0]    offset;
  logic [PAGE_W-1:0]    diff;
  logic [WIDE_W-1:0]    mark_end, hi_lim, off_end, span_wide;
  logic                 lo_fail, mark_fail, read_fail;
  logic [SpanW-1:0]     span_val;
  logic [COUNT_W-1:0]   run_inc;
  logic                 found;
  logic [IdxW-1:0]      found_calc;
  logic [SUM_W-1:0]     end_sum;

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= '0;
      highest_r <= PAGE_W'(4095);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOWEST_PAGE:  lowest_r  <= cfg_wdata;
        CFG_HIGHEST_PAGE: highest_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // bounds and span
  always_comb begin
    offset    = start_r - lowest_r;
    lo_fail   = start_r < lowest_r;
    mark_end  = WIDE_W'(start_r) + WIDE_W'(count_r);
    hi_lim    = WIDE_W'(highest_r) + WIDE_W'(1);
    off_end   = WIDE_W'(offset) + WIDE_W'(count_r);
    mark_fail = lo_fail || (mark_end > hi_lim) || (off_end > WIDE_W'(TABLE_PAGES));
    read_fail = lo_fail || (start_r > highest_r) ||
                (WIDE_W'(offset) >= WIDE_W'(TABLE_PAGES));
    diff      = highest_r - lowest_r;
    if (highest_r <= lowest_r) begin
      span_wide = '0;
    end else if (WIDE_W'(diff) > WIDE_W'(TABLE_PAGES)) begin
      span_wide = WIDE_W'(TABLE_PAGES);
    end else begin
      span_wide = WIDE_W'(diff);
    end
    span_val   = SpanW'(span_wide);
    run_inc    = (mem_rdata == TYPE_FREE) ? (run_r + COUNT_W'(1)) : '0;
    found      = rd_pending_r && (run_inc == count_r);
    found_calc = IdxW'(WIDE_W'(eval_idx_r) + WIDE_W'(1) - WIDE_W'(count_r));
    end_sum    = SUM_W'(lowest_r) + SUM_W'(found_idx_r) + SUM_W'(count_r);
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    start_nxt      = start_r;
    count_nxt      = count_r;
    type_nxt       = type_r;
    span_nxt       = span_r;
    issue_idx_nxt  = issue_idx_r;
    eval_idx_nxt   = eval_idx_r;
    rd_pending_nxt = rd_pending_r;
    run_nxt        = run_r;
    found_idx_nxt  = found_idx_r;
    wr_idx_nxt     = wr_idx_r;
    wr_left_nxt    = wr_left_r;
    wr_type_nxt    = wr_type_r;
    clr_idx_nxt    = clr_idx_r;
    res_nxt        = res_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = wr_idx_r;
    mem_wdata      = wr_type_r;
    mem_re         = 1'b0;
    mem_raddr      = IdxW'(offset);
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = TYPE_UNUSABLE;
        clr_idx_nxt = clr_idx_r + IdxW'(1);
        if (clr_idx_r == IdxW'(TABLE_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = op_t'(in_operation);
          start_nxt = in_start_page;
          count_nxt = in_page_count;
          type_nxt  = in_page_type;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt = '{status: STAT_OK, first_page: '0, read_type: '0};
        case (op_r)
          OP_MARK: begin
            if (mark_fail) begin
              res_nxt.status = STAT_BOUNDS;
              state_nxt      = S_RESP;
            end else if (count_r == '0) begin
              state_nxt = S_RESP;
            end else begin
              wr_idx_nxt  = IdxW'(offset);
              wr_left_nxt = count_r;
              wr_type_nxt = type_r;
              state_nxt   = S_WRITE;
            end
          end
          OP_ALLOC: begin
            if (count_r == '0) begin
              res_nxt.status = STAT_ZERO;
              state_nxt      = S_RESP;
            end else begin
              span_nxt       = span_val;
              issue_idx_nxt  = '0;
              rd_pending_nxt = 1'b0;
              run_nxt        = '0;
              state_nxt      = S_SCAN;
            end
          end
          OP_READ: begin
            if (read_fail) begin
              res_nxt.status = STAT_BOUNDS;
              state_nxt      = S_RESP;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (found) begin
          found_idx_nxt = found_calc;
          state_nxt     = S_CHECK;
        end else if (!rd_pending_r && (issue_idx_r >= span_r)) begin
          res_nxt.status = STAT_NOSPACE;
          state_nxt      = S_RESP;
        end else begin
          if (rd_pending_r) begin
            run_nxt = run_inc;
          end
          if (issue_idx_r < span_r) begin
            mem_re         = 1'b1;
            mem_raddr      = IdxW'(issue_idx_r);
            eval_idx_nxt   = IdxW'(issue_idx_r);
            issue_idx_nxt  = issue_idx_r + SpanW'(1);
            rd_pending_nxt = 1'b1;
          end else begin
            rd_pending_nxt = 1'b0;
          end
        end
      end
      S_CHECK: begin
        if (end_sum > ADDR_PAGE_LIMIT) begin
          res_nxt.status = STAT_ABOVE32;
          state_nxt      = S_RESP;
        end else begin
          res_nxt.first_page = lowest_r + PAGE_W'(found_idx_r);
          wr_idx_nxt         = found_idx_r;
          wr_left_nxt        = count_r;
          wr_type_nxt        = type_r;
          state_nxt          = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we      = 1'b1;
        wr_idx_nxt  = wr_idx_r + IdxW'(1);
        wr_left_nxt = wr_left_r - COUNT_W'(1);
        if (wr_left_r == COUNT_W'(1)) begin
          state_nxt = S_RESP;
        end
      end
      S_RDWAIT: begin
        res_nxt.read_type = mem_rdata;
        state_nxt         = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      rd_pending_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      rd_pending_r <= rd_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    start_r     <= start_nxt;
    count_r     <= count_nxt;
    type_r      <= type_nxt;
    span_r      <= span_nxt;
    issue_idx_r <= issue_idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    run_r       <= run_nxt;
    found_idx_r <= found_idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    wr_left_r   <= wr_left_nxt;
    wr_type_r   <= wr_type_nxt;
    res_r       <= res_nxt;
  end

  `PTMA_ASSERT_IMP(a_scan_in_span, (state_r == S_SCAN) && rd_pending_r, WIDE_W'(eval_idx_r) < WIDE_W'(span_r), "scan evaluated an entry past the search span")
  `PTMA_ASSERT_IMP(a_write_in_table, mem_we, WIDE_W'(mem_waddr) < WIDE_W'(TABLE_PAGES), "write beyond table depth")
  `PTMA_ASSERT_NXT(a_fill_ends, (state_r == S_WRITE) && (wr_left_r == COUNT_W'(1)), state_r == S_RESP, "fill did not end after last entry")
  `PTMA_ASSERT_IMP(a_fail_zero, res_valid && (res_r.status != STAT_OK), (res_r.first_page == '0) && (res_r.read_type == '0), "failing result carries nonzero fields")

endmodule
